### src/tw_pkg.sv
// ----------------------------------------------------------------------------
// tw_pkg
// Shared types, codes, constants and the 2^-x table of the tween engine.
// ----------------------------------------------------------------------------
package tw_pkg;

  localparam int CHANNELS        = 32;
  localparam int EXP_TABLE_DEPTH = 64;
  localparam int ADDR_W          = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int EXP_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int POS_W           = 16 + $clog2(EXP_TABLE_DEPTH + 1);

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_START   = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_BACK   = 2'd1;
  localparam logic [1:0] CURVE_EXPO   = 2'd2;

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_UPDATE  = 2'd1;
  localparam logic [1:0] KIND_RELEASE = 2'd2;

  localparam logic signed [18:0] BACK_C1 = 19'sd111515;
  localparam logic signed [18:0] BACK_C3 = 19'sd177051;
  localparam logic [23:0] ELAPSED_MAX    = 24'hFFFFFF;
  localparam logic [31:0] EXP_HALF_Q30   = 32'h2000_0000;

  typedef struct packed {
    logic [15:0]        target;
    logic signed [31:0] start;
    logic signed [31:0] goal;
    logic [15:0]        duration;
    logic [23:0]        elapsed;
    logic [1:0]         curve;
  } rec_t;

  typedef logic [31:0] exp_tab_t [EXP_TABLE_DEPTH];

  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bt;
    v   = v_in;
    res = '0;
    bt  = 64'd1 << 62;
    for (int j = 0; j < 32; j++) begin
      if (v >= res + bt) begin
        v   = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // Q30 entries 2^(-k/D), built from a chain of square roots of one half
  function automatic exp_tab_t exp_tab_build();
    logic [63:0] chain [17];
    logic [63:0] acc;
    logic [15:0] fr;
    exp_tab_t    tab;
    chain[0] = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) chain[i] = isqrt64(chain[i-1] << 30);
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      fr  = 16'((64'(k) << 16) / EXP_TABLE_DEPTH);
      acc = 64'd1 << 30;
      for (int i = 1; i <= 16; i++) begin
        if (fr[16-i]) acc = (acc * chain[i]) >> 30;
      end
      tab[k] = acc[31:0];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = exp_tab_build();

endpackage

### src/tw_store.sv
// ----------------------------------------------------------------------------
// tw_store
// Channel record memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tw_store import tw_pkg::*; (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  rec_t              wr_data,
  output rec_t              rd_data
);

  rec_t mem [CHANNELS];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

### src/tw_calc.sv
// ----------------------------------------------------------------------------
// tw_calc
// Per-channel easing datapath: serial divide, curve steps, final scale.
// ----------------------------------------------------------------------------
module tw_calc import tw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  rec_t               rec,
  output logic               done,
  output logic signed [31:0] value,
  output logic               fin
);

  localparam logic [3:0] C_IDLE  = 4'd0;
  localparam logic [3:0] C_DIV   = 4'd1;
  localparam logic [3:0] C_CURVE = 4'd2;
  localparam logic [3:0] C_B1    = 4'd3;
  localparam logic [3:0] C_B2    = 4'd4;
  localparam logic [3:0] C_B3    = 4'd5;
  localparam logic [3:0] C_B4    = 4'd6;
  localparam logic [3:0] C_E1    = 4'd7;
  localparam logic [3:0] C_E2    = 4'd8;
  localparam logic [3:0] C_MUL   = 4'd9;
  localparam logic [3:0] C_SAT   = 4'd10;

  logic [3:0]         state;
  logic [3:0]         cnt;
  logic [15:0]        rem_r;
  logic [15:0]        quo;
  logic [15:0]        du_r;
  logic [16:0]        t;
  logic [1:0]         curve_r;
  logic signed [31:0] start_r;
  logic signed [32:0] diff_r;
  logic signed [17:0] u2;
  logic signed [17:0] u3;
  logic signed [18:0] ca;
  logic signed [19:0] f;
  logic [31:0]        ea;
  logic [31:0]        ed;
  logic [15:0]        erem;
  logic [3:0]         en;
  logic signed [52:0] prod;

  // divide step
  logic [16:0] div_sh;
  logic [16:0] div_sub;
  logic        div_ge;
  assign div_sh  = {rem_r, 1'b0};
  assign div_ge  = div_sh >= {1'b0, du_r};
  assign div_sub = div_sh - {1'b0, du_r};

  // ease out back
  logic signed [17:0] u;
  logic signed [35:0] p_uu;
  logic signed [35:0] p_u2u;
  logic signed [36:0] p_c3;
  logic signed [36:0] p_c1;
  assign u     = $signed({1'b0, t}) - 18'sd65536;
  assign p_uu  = u * u;
  assign p_u2u = u2 * u;
  assign p_c3  = BACK_C3 * 19'(u3);
  assign p_c1  = BACK_C1 * 19'(u2);

  // ease out expo
  logic [19:0]          ex;
  logic [POS_W-1:0]     pos;
  logic [EXP_IDX_W-1:0] k;
  logic [EXP_IDX_W-1:0] k_nx;
  logic [31:0]          ta;
  logic [31:0]          tb;
  logic [47:0]          dv;
  logic [31:0]          ev;
  logic [31:0]          es;
  assign ex   = 20'(t[15:0]) * 20'd10;
  assign pos  = POS_W'(ex[15:0]) * POS_W'(EXP_TABLE_DEPTH);
  assign k    = pos[16 +: EXP_IDX_W];
  assign k_nx = k + 1'b1;
  assign ta   = EXP_TAB[k];
  assign tb   = (k == EXP_IDX_W'(EXP_TABLE_DEPTH - 1)) ? EXP_HALF_Q30 : EXP_TAB[k_nx];
  assign dv   = 48'(ed) * 48'(erem);
  assign ev   = ea - dv[47:16];
  assign es   = ev >> (5'(en) + 5'd14);

  // final scale
  logic signed [52:0] p_fin;
  logic signed [37:0] vsum;
  assign p_fin = diff_r * f;
  assign vsum  = 38'(start_r) + 38'($signed(prod[52:16]));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          if (go) begin
            curve_r <= rec.curve;
            start_r <= rec.start;
            diff_r  <= 33'(rec.goal) - 33'(rec.start);
            du_r    <= rec.duration;
            if (rec.duration == 16'd0 || rec.elapsed >= {8'd0, rec.duration}) begin
              t     <= 17'h10000;
              state <= C_CURVE;
            end else begin
              rem_r <= rec.elapsed[15:0];
              quo   <= '0;
              cnt   <= '0;
              state <= C_DIV;
            end
          end
        end
        C_DIV: begin
          rem_r <= div_ge ? div_sub[15:0] : div_sh[15:0];
          quo   <= {quo[14:0], div_ge};
          cnt   <= cnt + 4'd1;
          if (cnt == 4'd15) begin
            t     <= {1'b0, quo[14:0], div_ge};
            state <= C_CURVE;
          end
        end
        C_CURVE: begin
          fin <= t[16];
          case (curve_r)
            CURVE_BACK: state <= C_B1;
            CURVE_EXPO: begin
              if (t[16]) begin
                f     <= 20'sd65536;
                state <= C_MUL;
              end else begin
                state <= C_E1;
              end
            end
            default: begin
              f     <= $signed(20'(t));
              state <= C_MUL;
            end
          endcase
        end
        C_B1: begin
          u2    <= p_uu[33:16];
          state <= C_B2;
        end
        C_B2: begin
          u3    <= p_u2u[33:16];
          state <= C_B3;
        end
        C_B3: begin
          ca    <= p_c3[34:16];
          state <= C_B4;
        end
        C_B4: begin
          f     <= 20'sd65536 + 20'(ca) + 20'(p_c1[34:16]);
          state <= C_MUL;
        end
        C_E1: begin
          ea    <= ta;
          ed    <= (ta >= tb) ? ta - tb : 32'd0;
          erem  <= pos[15:0];
          en    <= ex[19:16];
          state <= C_E2;
        end
        C_E2: begin
          f     <= 20'sd65536 - $signed(20'(es));
          state <= C_MUL;
        end
        C_MUL: begin
          prod  <= p_fin;
          state <= C_SAT;
        end
        C_SAT: begin
          if (vsum > 38'sd2147483647)       value <= 32'sh7FFF_FFFF;
          else if (vsum < -38'sd2147483648) value <= 32'sh8000_0000;
          else                              value <= vsum[31:0];
          done  <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### src/multi_channel_easing_interpolator.sv
// ----------------------------------------------------------------------------
// multi_channel_easing_interpolator
// Table of animation channels eased in Q16.16 on every tick word.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one command word: tick, start or
// release. Output channel (out_valid/out_ready) returns result words, the one
// with last set closing each command. A start answers with the claimed slot
// (lowest free) or accepted=0 when full; a release answers with the slot's
// target and finished flag. A tick returns one update word per active slot,
// in slot order; with no active slot it returns nothing.
// One command is in work at a time. A tick walks each active slot in turn:
// memory read, a serial divide for t (skipped once t has reached one), the
// curve multiply steps (more for ease out expo, most for ease out back) and
// the final scale.
// in_ready is high whenever the sequencer is idle, even while a result word
// still waits in the output register. A stalled receiver holds the walk.
// Reset clears the active and finished flags; record memory needs no clear.
// ----------------------------------------------------------------------------
module multi_channel_easing_interpolator import tw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         command,
  input  logic [15:0]        target,
  input  logic signed [31:0] start_value,
  input  logic signed [31:0] goal_value,
  input  logic [15:0]        duration,
  input  logic [1:0]         curve,
  input  logic [15:0]        delta,
  input  logic [5:0]         slot,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         kind,
  output logic               accepted,
  output logic [5:0]         slot_index,
  output logic [15:0]        target_id,
  output logic signed [31:0] eased_value,
  output logic               finished,
  output logic               last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_REL   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_TGO   = 3'd4;
  localparam logic [2:0] S_TWAIT = 3'd5;
  localparam logic [2:0] S_TOUT  = 3'd6;

  logic [2:0]          state;
  logic [CHANNELS-1:0] active;
  logic [CHANNELS-1:0] fin_flag;
  logic [ADDR_W-1:0]   cur;

  logic [15:0]        tgt_r;
  logic signed [31:0] sv_r;
  logic signed [31:0] gv_r;
  logic [15:0]        du_r;
  logic [1:0]         cv_r;
  logic [15:0]        dt_r;
  logic [5:0]         sl_r;

  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr;
  rec_t               wr_data;
  rec_t               rd_data;

  logic               calc_go;
  logic               calc_done;
  logic signed [31:0] calc_value;
  logic               calc_fin;

  logic               out_free;
  logic               emit;
  assign out_free = !out_valid || out_ready;
  assign emit     = out_free && (state == S_START || state == S_REL || state == S_TOUT);
  assign in_ready = (state == S_IDLE);

  // lowest free slot, next active slot at or past cur, any active past cur
  logic              free_hit;
  logic [ADDR_W-1:0] free_idx;
  logic              scan_hit;
  logic [ADDR_W-1:0] scan_idx;
  logic              more;
  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    scan_hit = 1'b0;
    scan_idx = '0;
    more     = 1'b0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_hit = 1'b1;
        free_idx = ADDR_W'(i);
      end
      if (active[i] && ADDR_W'(i) >= cur) begin
        scan_hit = 1'b1;
        scan_idx = ADDR_W'(i);
      end
      if (active[i] && ADDR_W'(i) > cur) more = 1'b1;
    end
  end

  logic              rel_in_range;
  logic [ADDR_W-1:0] rel_addr;
  logic              rel_ok;
  assign rel_in_range = {1'b0, sl_r} < 7'(CHANNELS);
  assign rel_addr     = sl_r[ADDR_W-1:0];
  assign rel_ok       = rel_in_range && active[rel_addr];

  logic [24:0] el_sum;
  assign el_sum = {1'b0, rd_data.elapsed} + 25'(dt_r);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_idx;
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = rd_data;
    calc_go = (state == S_TGO);
    if (state == S_IDLE && in_valid && command == CMD_RELEASE) begin
      rd_en   = 1'b1;
      rd_addr = slot[ADDR_W-1:0];
    end
    if (state == S_SCAN && scan_hit) rd_en = 1'b1;
    if (state == S_START && out_free && free_hit) begin
      wr_en   = 1'b1;
      wr_addr = free_idx;
      wr_data = '{target: tgt_r, start: sv_r, goal: gv_r, duration: du_r,
                  elapsed: 24'd0, curve: cv_r};
    end
    if (state == S_TOUT && out_free) begin
      wr_en           = 1'b1;
      wr_data.elapsed = el_sum[24] ? ELAPSED_MAX : el_sum[23:0];
    end
  end

  tw_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  tw_calc u_calc (
    .clk   (clk),
    .rst   (rst),
    .go    (calc_go),
    .rec   (rd_data),
    .done  (calc_done),
    .value (calc_value),
    .fin   (calc_fin)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      active    <= '0;
      fin_flag  <= '0;
      cur       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tgt_r <= target;
            sv_r  <= start_value;
            gv_r  <= goal_value;
            du_r  <= duration;
            cv_r  <= curve;
            dt_r  <= delta;
            sl_r  <= slot;
            case (command)
              CMD_START:   state <= S_START;
              CMD_RELEASE: state <= S_REL;
              CMD_TICK: begin
                cur   <= '0;
                state <= S_SCAN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_START: begin
          if (out_free) begin
            kind        <= KIND_START;
            accepted    <= free_hit;
            slot_index  <= free_hit ? 6'(free_idx) : 6'd0;
            target_id   <= tgt_r;
            eased_value <= free_hit ? sv_r : 32'sd0;
            finished    <= 1'b0;
            last        <= 1'b1;
            if (free_hit) begin
              active[free_idx]   <= 1'b1;
              fin_flag[free_idx] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_REL: begin
          if (out_free) begin
            kind        <= KIND_RELEASE;
            accepted    <= rel_ok;
            slot_index  <= sl_r;
            target_id   <= rel_ok ? rd_data.target : 16'd0;
            eased_value <= 32'sd0;
            finished    <= rel_ok && fin_flag[rel_addr];
            last        <= 1'b1;
            if (rel_ok) begin
              active[rel_addr]   <= 1'b0;
              fin_flag[rel_addr] <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            cur   <= scan_idx;
            state <= S_TGO;
          end else begin
            state <= S_IDLE;
          end
        end
        S_TGO: state <= S_TWAIT;
        S_TWAIT: if (calc_done) state <= S_TOUT;
        S_TOUT: begin
          if (out_free) begin
            kind        <= KIND_UPDATE;
            accepted    <= 1'b0;
            slot_index  <= 6'(cur);
            target_id   <= rd_data.target;
            eased_value <= calc_value;
            finished    <= calc_fin;
            last        <= !more;
            if (calc_fin) fin_flag[cur] <= 1'b1;
            if (more) begin
              cur   <= cur + 1'b1;
              state <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_calc_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    calc_done |-> state == S_TWAIT)
    else $error("datapath finished outside of the wait state");

  a_write_owner: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_START || state == S_TOUT))
    else $error("record write outside start or tick output");

  a_tick_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_TOUT && out_free && !more) |=> state == S_IDLE && out_valid && last)
    else $error("final tick word did not close the command");

  a_start_claims_free: assert property (@(posedge clk) disable iff (rst)
    (state == S_START && out_free && free_hit) |=> active[$past(free_idx)])
    else $error("claimed slot not marked active");

endmodule

### tb/easing_result_checker.sv
// ----------------------------------------------------------------------------
// easing_result_checker
// Watches both channels of the tween engine, predicts each result word from
// its own copy of the channel table, and compares words field by field.
// ----------------------------------------------------------------------------
module easing_result_checker import tw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         command,
  input  logic [15:0]        target,
  input  logic signed [31:0] start_value,
  input  logic signed [31:0] goal_value,
  input  logic [15:0]        duration,
  input  logic [1:0]         curve,
  input  logic [15:0]        delta,
  input  logic [5:0]         slot,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         kind,
  input  logic               accepted,
  input  logic [5:0]         slot_index,
  input  logic [15:0]        target_id,
  input  logic signed [31:0] eased_value,
  input  logic               finished,
  input  logic               last,
  output int                 fail_count,
  output int                 words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          TAB_N  = 64;
  localparam longint      ONE    = 65536;
  localparam longint      C1     = 111515;
  localparam longint      C3     = 177051;

  typedef struct {
    logic [1:0]         kind;
    logic               acc;
    logic [5:0]         idx;
    logic [15:0]        tgt;
    logic signed [31:0] val;
    logic               fin;
    logic               last;
  } word_t;

  word_t              due_q[$];
  logic [31:0]        exp_q30 [TAB_N];
  logic               ch_act [CHANNELS];
  logic               ch_fin [CHANNELS];
  logic [15:0]        ch_tgt [CHANNELS];
  logic signed [31:0] ch_from [CHANNELS];
  logic signed [31:0] ch_to [CHANNELS];
  logic [15:0]        ch_dur [CHANNELS];
  logic [23:0]        ch_el [CHANNELS];
  logic [1:0]         ch_crv [CHANNELS];
  int                 fails;

  assign fail_count = fails;
  assign words_due  = due_q.size();

  function automatic logic [63:0] root_floor(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-k/64) in Q30 from successive square roots of one half
  initial begin
    logic [63:0] chain [17];
    logic [63:0] acc;
    logic [15:0] fr;
    chain[0] = 64'd1 << 29;
    for (int i = 1; i <= 16; i++) chain[i] = root_floor(chain[i-1] << 30);
    for (int k = 0; k < TAB_N; k++) begin
      fr  = 16'((64'(k) << 16) / TAB_N);
      acc = 64'd1 << 30;
      for (int i = 1; i <= 16; i++)
        if (fr[16-i]) acc = (acc * chain[i]) >> 30;
      exp_q30[k] = acc[31:0];
    end
  end

  function automatic longint ease_factor(input logic [1:0] crv, input longint t);
    longint u, u2, u3;
    logic [31:0] x, n, fr, pos, k, rem, a, b, v;
    if (crv == CURVE_BACK) begin
      u  = t - ONE;
      u2 = (u * u) >>> 16;
      u3 = (u2 * u) >>> 16;
      return ONE + ((C3 * u3) >>> 16) + ((C1 * u2) >>> 16);
    end
    if (crv == CURVE_EXPO) begin
      if (t >= ONE) return ONE;
      x   = 32'(t) * 10;
      n   = x >> 16;
      fr  = x & 32'hFFFF;
      pos = fr * TAB_N;
      k   = pos >> 16;
      rem = pos & 32'hFFFF;
      if (k >= TAB_N) k = TAB_N - 1;
      a = exp_q30[k];
      b = (k + 1 < TAB_N) ? exp_q30[k+1] : 32'h2000_0000;
      v = (a >= b) ? a - 32'((64'(a - b) * 64'(rem)) >> 16) : a;
      v = (n < 32) ? v >> n : 0;
      return ONE - longint'(v >> 14);
    end
    return t;
  endfunction

  function automatic word_t make_word(input logic [1:0] kd, input logic ac,
      input logic [5:0] ix, input logic [15:0] tg, input logic signed [31:0] vl,
      input logic fn, input logic ls);
    word_t w;
    w.kind = kd; w.acc = ac; w.idx = ix; w.tgt = tg; w.val = vl; w.fin = fn;
    w.last = ls;
    return w;
  endfunction

  task automatic report(input string field, input longint got, input longint want);
    $display("%0t: result word field %s is %0h, expected %0h", $time, field, got, want);
    fails++;
  endtask

  task automatic predict_command();
    int          hits;
    int          free_slot;
    longint      t, diff, val;
    logic [24:0] sum;
    logic        fin;
    hits      = 0;
    free_slot = -1;
    case (command)
      CMD_START: begin
        for (int i = CHANNELS - 1; i >= 0; i--) if (!ch_act[i]) free_slot = i;
        if (free_slot < 0) begin
          due_q.push_back(make_word(KIND_START, 0, 0, target, 0, 0, 1));
        end else begin
          ch_act[free_slot]  = 1;
          ch_fin[free_slot]  = 0;
          ch_tgt[free_slot]  = target;
          ch_from[free_slot] = start_value;
          ch_to[free_slot]   = goal_value;
          ch_dur[free_slot]  = duration;
          ch_el[free_slot]   = 0;
          ch_crv[free_slot]  = curve;
          due_q.push_back(make_word(KIND_START, 1, 6'(free_slot), target, start_value,
                                    0, 1));
        end
      end
      CMD_RELEASE: begin
        if (slot < CHANNELS && ch_act[slot]) begin
          due_q.push_back(make_word(KIND_RELEASE, 1, slot, ch_tgt[slot], 0,
                                    ch_fin[slot], 1));
          ch_act[slot] = 0;
          ch_fin[slot] = 0;
        end else begin
          due_q.push_back(make_word(KIND_RELEASE, 0, slot, 0, 0, 0, 1));
        end
      end
      CMD_TICK: begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (ch_act[i]) begin
            if (ch_dur[i] == 0 || ch_el[i] >= ch_dur[i]) t = ONE;
            else t = longint'((64'(ch_el[i]) << 16) / ch_dur[i]);
            diff = longint'(ch_to[i]) - longint'(ch_from[i]);
            val  = longint'(ch_from[i]) + ((diff * ease_factor(ch_crv[i], t)) >>> 16);
            if (val > 64'sd2147483647) val = 64'sd2147483647;
            if (val < -64'sd2147483648) val = -64'sd2147483648;
            fin = (t >= ONE);
            if (fin) ch_fin[i] = 1;
            due_q.push_back(make_word(KIND_UPDATE, 0, 6'(i), ch_tgt[i], 32'(val), fin, 0));
            hits++;
            sum = 25'(ch_el[i]) + 25'(delta);
            ch_el[i] = sum[24] ? 24'hFFFFFF : sum[23:0];
          end
        end
        if (hits > 0) due_q[due_q.size()-1].last = 1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    word_t w;
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ch_act[i] = 0;
        ch_fin[i] = 0;
      end
      due_q.delete();
      fails = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          $display("%0t: result word with none expected", $time);
          fails++;
        end else begin
          w = due_q.pop_front();
          if (kind !== w.kind) report("kind", kind, w.kind);
          if (accepted !== w.acc) report("accepted", accepted, w.acc);
          if (slot_index !== w.idx) report("slot_index", slot_index, w.idx);
          if (target_id !== w.tgt) report("target_id", target_id, w.tgt);
          if (eased_value !== w.val) report("eased_value", eased_value, w.val);
          if (finished !== w.fin) report("finished", finished, w.fin);
          if (last !== w.last) report("last", last, w.last);
        end
      end
      if (in_valid && in_ready) predict_command();
    end
  end

endmodule

### tb/multi_channel_easing_interpolator_test.sv
// ----------------------------------------------------------------------------
// multi_channel_easing_interpolator_test
// Drives tick, start and release words with random gaps and output stalls;
// the checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module multi_channel_easing_interpolator_test;
  import tw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_NONE = 2'd3;

  logic               clk = 0;
  logic               rst = 1;
  logic               in_valid = 0;
  logic               in_ready;
  logic [1:0]         command = CMD_TICK;
  logic [15:0]        target = 0;
  logic signed [31:0] start_value = 0;
  logic signed [31:0] goal_value = 0;
  logic [15:0]        duration = 0;
  logic [1:0]         curve = CURVE_LINEAR;
  logic [15:0]        delta = 0;
  logic [5:0]         slot = 0;
  logic               out_valid;
  logic               out_ready = 0;
  logic [1:0]         kind;
  logic               accepted;
  logic [5:0]         slot_index;
  logic [15:0]        target_id;
  logic signed [31:0] eased_value;
  logic               finished;
  logic               last;
  int                 fail_count;
  int                 words_due;
  logic               steady = 0;

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  multi_channel_easing_interpolator DUT (.*);

  easing_result_checker watch (.*);

  task automatic send(input logic [1:0] cmd, input logic [15:0] tg,
      input logic [31:0] sv, input logic [31:0] gv, input logic [15:0] du,
      input logic [1:0] cv, input logic [15:0] dt, input logic [5:0] sl);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1;
    command     <= cmd;
    target      <= tg;
    start_value <= sv;
    goal_value  <= gv;
    duration    <= du;
    curve       <= cv;
    delta       <= dt;
    slot        <= sl;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic start_tween(input logic [15:0] tg, input logic [31:0] sv,
      input logic [31:0] gv, input logic [15:0] du, input logic [1:0] cv);
    send(CMD_START, tg, sv, gv, du, cv, 16'($urandom), 6'($urandom));
  endtask

  task automatic tick(input logic [15:0] dt);
    send(CMD_TICK, 16'($urandom), $urandom, $urandom, 16'($urandom), 2'($urandom), dt,
         6'($urandom));
  endtask

  task automatic drop(input logic [5:0] sl);
    send(CMD_RELEASE, 16'($urandom), $urandom, $urandom, 16'($urandom), 2'($urandom),
         16'($urandom), sl);
  endtask

  function automatic logic [31:0] any_value();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] any_time();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 4));
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 40));
    endcase
  endfunction

  // receiver: may stall before each word
  initial begin
    int gap;
    @(negedge rst);
    @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        out_ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #20_000_000;
    $display("multi_channel_easing_interpolator verification failed");
    $finish;
  end

  initial begin
    int pick;
    int waited;
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // idle table: tick gives nothing, unused code, releases that miss
    tick(16'hFFFF);
    send(CMD_NONE, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 16'hFFFF,
         6'h3F);
    drop(6'd5);
    drop(6'd63);

    // one long channel driven with large back to back ticks
    start_tween(16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, CURVE_LINEAR);
    steady = 1;
    repeat (8) tick(16'hFFFF);
    steady = 0;
    drop(6'd0);
    drop(6'd0);

    // every curve, instant and short durations, overshoot that saturates
    start_tween(16'h0000, 32'h0000_0000, 32'h0001_0000, 16'd0, CURVE_LINEAR);
    start_tween(16'h1234, 32'h8000_0000, 32'h7FFF_FFFF, 16'd10, CURVE_BACK);
    start_tween(16'h5678, 32'hFFF0_0000, 32'h0010_0000, 16'd10, CURVE_EXPO);
    start_tween(16'h9ABC, 32'h0000_0000, 32'hFFFF_0000, 16'd1, 2'd3);
    start_tween(16'hDEF0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, CURVE_EXPO);
    start_tween(16'h0F0F, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, CURVE_BACK);
    tick(16'd0);
    tick(16'd1);
    tick(16'd5);
    tick(16'd3);
    tick(16'hFFFF);
    drop(6'd1);
    drop(6'd2);
    tick(16'd2);

    // random phase: fill toward full early, then mixed traffic
    for (int n = 0; n < 105; n++) begin
      if (n % 20 == 0) steady = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (n < 45) pick = pick / 2;
      if (pick < 40) begin
        start_tween(16'($urandom), any_value(), any_value(), any_time(), 2'($urandom));
      end else if (pick < 72) begin
        tick(any_time());
      end else if (pick < 95) begin
        drop(($urandom_range(0, 4) == 0) ? 6'($urandom) : 6'($urandom_range(0, 31)));
      end else begin
        send(CMD_NONE, 16'($urandom), $urandom, $urandom, 16'($urandom), 2'($urandom),
             16'($urandom), 6'($urandom));
      end
    end
    steady = 0;
    in_valid <= 0;

    waited = 0;
    do begin
      @(posedge clk);
      #1;
      waited++;
    end while (words_due != 0 && waited < 200_000);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && words_due == 0)
      $display("multi_channel_easing_interpolator verification clean");
    else
      $display("multi_channel_easing_interpolator verification failed");
    $finish;
  end

endmodule
